// File: sv/assert_macros.svh
// assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// File: sv/rhom_pkg.sv
// shared types and constants of the overlap merge block
package rhom_pkg;
  localparam int MergedDepth = 65536;
  localparam int WordDepth = 4096;
  localparam int MAW = $clog2(MergedDepth);
  localparam int WAW = $clog2(WordDepth);
  localparam int MCW = MAW + 1;
  localparam int WCW = WAW + 1;
  localparam logic [29:0] HashMod = 30'd998244353;
  localparam logic [29:0] HashBase = 30'd291143;
  // barrett factor floor(2^60 / modulus)
  localparam logic [30:0] HashMu = 31'((64'd1 << 60) / {34'd0, HashMod});

  typedef enum logic [0:0] {OP_PUSH = 1'b0, OP_READ = 1'b1} op_t;
  typedef enum logic [0:0] {KIND_MERGE = 1'b0, KIND_READ = 1'b1} kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_RWAIT, S_LREAD, S_LMUL, S_LRED, S_LCMP, S_APREAD, S_APWR, S_OUT
  } state_t;

  typedef struct packed {
    logic take;      // capture input beat
    logic push;      // store word byte
    logic rd_issue;  // issue read of merged text
    logic loop_init;
    logic loop_read;
    logic loop_red;
    logic loop_cmp;
    logic ap_init;
    logic ap_read;
    logic ap_write;
    logic load_out;
    logic out_kind;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_end;
    logic loop_done;
    logic ap_done;
  } stat_t;

  // reduce a value below twice the modulus
  function automatic logic [29:0] mod_red(input logic [30:0] s);
    logic [30:0] d;
    d = s - {1'b0, HashMod};
    return (s >= {1'b0, HashMod}) ? d[29:0] : s[29:0];
  endfunction
endpackage

// File: sv/rhom_if.sv
// valid/ready channel interfaces
interface rhom_in_if (input logic clk);
  logic valid;
  logic ready;
  logic op;
  logic [7:0] char_code;
  logic word_end;
  logic [15:0] read_index;
  modport source (output valid, op, char_code, word_end, read_index, input ready);
  modport sink (input valid, op, char_code, word_end, read_index, output ready);
endinterface

interface rhom_out_if (input logic clk);
  logic valid;
  logic ready;
  logic kind;
  logic [12:0] overlap_len;
  logic [16:0] merged_len;
  logic [7:0] read_byte;
  logic overflow;
  modport source (output valid, kind, overlap_len, merged_len, read_byte, overflow,
    input ready);
  modport sink (input valid, kind, overlap_len, merged_len, read_byte, overflow,
    output ready);
endinterface

// File: sv/rolling_hash_overlap_merge.sv
// top level of the suffix-prefix overlap merge block
// channel | dir | fields
// in      | in  | op, char_code, word_end, read_index
// out     | out | kind, overlap_len, merged_len, read_byte, overflow
// a push beat without word end passes S_IDLE and S_READ, a read beat also
// S_RWAIT and S_OUT; a word end passes S_LREAD, S_LMUL, S_LRED and S_LCMP
// per overlap length checked (four-stage multipliers in the hash loop) and
// S_APREAD, S_APWR per appended byte; one beat at a time; a waiting result
// blocks the next beat; rst is synchronous; buffers need no clearing pass
module rolling_hash_overlap_merge (
  input logic clk,
  input logic rst,
  rhom_in_if.sink in,
  rhom_out_if.source out
);
  import rhom_pkg::*;
  cmd_t cmd;
  stat_t stat;

  rhom_ctrl u_ctrl (.clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .stat(stat), .cmd(cmd));

  rhom_datapath u_dp (.clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_op(in.op), .in_char(in.char_code), .in_end(in.word_end), .in_idx(in.read_index),
    .o_kind(out.kind), .o_overlap(out.overlap_len), .o_mlen(out.merged_len),
    .o_byte(out.read_byte), .o_ovf(out.overflow));
endmodule

// File: sv/rhom_mulmod.sv
// modular multiply, four stages: multiply, quotient estimate, remainder, correction
module rhom_mulmod (
  input  logic        clk,
  input  logic [29:0] a,
  input  logic [29:0] b,
  output logic [29:0] p
);
  import rhom_pkg::*;
  logic [59:0] prod, prod_d;
  logic [61:0] qprod;
  logic [30:0] q;
  logic [31:0] qm;
  logic [31:0] r;
  logic [31:0] r1, r2;

  assign qprod = {31'd0, prod[59:29]} * {31'd0, HashMu};
  assign qm = {1'b0, q} * {2'b0, HashMod};
  assign r1 = r - {2'b0, HashMod};
  assign r2 = r - {1'b0, HashMod, 1'b0};

  always_ff @(posedge clk) begin
    prod <= a * b;
    prod_d <= prod;
    q <= qprod[61:31];
    r <= prod_d[31:0] - qm;
    if (r >= {1'b0, HashMod, 1'b0}) p <= r2[29:0];
    else if (r >= {2'b0, HashMod}) p <= r1[29:0];
    else p <= r[29:0];
  end
endmodule

// File: sv/rhom_datapath.sv
// buffers, counters and hash datapath
module rhom_datapath (
  input  logic          clk,
  input  logic          rst,
  input  rhom_pkg::cmd_t cmd,
  output rhom_pkg::stat_t stat,
  input  logic          in_op,
  input  logic [7:0]    in_char,
  input  logic          in_end,
  input  logic [15:0]   in_idx,
  output logic          o_kind,
  output logic [12:0]   o_overlap,
  output logic [16:0]   o_mlen,
  output logic [7:0]    o_byte,
  output logic          o_ovf
);
  import rhom_pkg::*;
  logic [7:0] mtext [MergedDepth];
  logic [7:0] wbuf [WordDepth];
  logic [MCW-1:0] mcount;
  logic [WCW-1:0] wcount, wcount_inc;
  logic ovf;
  logic op_r, end_r;
  logic [7:0] ch_r;
  logic [15:0] idx_r;
  logic [7:0] mrd, wrd;
  logic [WCW-1:0] j, limit, best, k;
  logic [29:0] suf, pre, pw, mul_a, mul_b, mp1, mp2;
  logic [30:0] suf_sum, pre_sum;
  logic [MAW-1:0] maddr;
  logic [WAW-1:0] waddr;
  logic [29:0] pwn;

  rhom_mulmod u_m1 (.clk(clk), .a(mul_a), .b(pw), .p(mp1));
  rhom_mulmod u_m2 (.clk(clk), .a(pre), .b(mul_b), .p(mp2));
  // power update uses its own multiplier pass
  rhom_mulmod u_m3 (.clk(clk), .a(pw), .b(HashBase), .p(pwn));
  assign mul_a = {22'd0, mrd};
  assign mul_b = HashBase;

  assign suf_sum = {1'b0, suf} + {1'b0, mp1};
  assign pre_sum = {1'b0, mp2} + {23'd0, wrd};
  assign wcount_inc = (wcount < WCW'(WordDepth)) ? wcount + 1'b1 : wcount;

  assign stat.is_read = op_r;
  assign stat.is_end = end_r;
  assign stat.loop_done = (j >= limit);
  assign stat.ap_done = (k >= wcount);

  always_comb begin
    maddr = idx_r[MAW-1:0];
    waddr = k[WAW-1:0];
    if (cmd.loop_read) begin
      maddr = MAW'(mcount - MCW'(j) - 1'b1);
      waddr = j[WAW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue || cmd.loop_read) mrd <= mtext[maddr];
    if (cmd.ap_read || cmd.loop_read) wrd <= wbuf[waddr];
    if (cmd.take) begin
      op_r <= in_op; ch_r <= in_char; end_r <= in_end; idx_r <= in_idx;
    end
    if (cmd.push && wcount < WCW'(WordDepth)) wbuf[wcount[WAW-1:0]] <= ch_r;
    if (cmd.ap_write && mcount < MCW'(MergedDepth)) mtext[mcount[MAW-1:0]] <= wrd;
    if (cmd.loop_init) begin
      j <= '0; best <= '0; suf <= '0; pre <= '0; pw <= 30'd1;
      limit <= (mcount < MCW'(wcount_inc)) ? WCW'(mcount) : wcount_inc;
    end
    if (cmd.loop_red) begin
      suf <= mod_red(suf_sum);
      pre <= mod_red(pre_sum);
    end
    if (cmd.loop_cmp) begin
      j <= j + 1'b1;
      pw <= pwn;
      if (suf == pre) best <= j + 1'b1;
    end
    if (cmd.ap_init) k <= best;
    if (cmd.ap_write) k <= k + 1'b1;
    if (cmd.load_out) begin
      o_kind <= cmd.out_kind;
      o_mlen <= 17'(mcount);
      o_ovf <= ovf;
      o_overlap <= cmd.out_kind ? 13'd0 : 13'(best);
      o_byte <= (cmd.out_kind && MCW'(idx_r) < mcount) ? mrd : 8'd0;
    end
    if (rst) begin
      mcount <= '0; wcount <= '0; ovf <= 1'b0;
    end else begin
      if (cmd.push) begin
        if (wcount < WCW'(WordDepth)) wcount <= wcount + 1'b1;
        else ovf <= 1'b1;
      end
      if (cmd.ap_write) begin
        if (mcount < MCW'(MergedDepth)) mcount <= mcount + 1'b1;
        else ovf <= 1'b1;
      end
      if (cmd.load_out && !cmd.out_kind) wcount <= '0;
    end
  end
endmodule

// File: sv/rhom_ctrl.sv
// controller state machine
module rhom_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  rhom_pkg::stat_t stat,
  output rhom_pkg::cmd_t  cmd
);
  import rhom_pkg::*;
  state_t state, state_next;
  logic [1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; cnt <= '0;
    end else begin
      state <= state_next; cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (stat.is_read) begin
          cmd.rd_issue = 1'b1;
          state_next = S_RWAIT;
        end else begin
          cmd.push = 1'b1;
          if (stat.is_end) state_next = S_LREAD;
          else state_next = S_IDLE;
          cmd.loop_init = stat.is_end;
        end
      end
      S_RWAIT: begin
        cmd.load_out = 1'b1; cmd.out_kind = KIND_READ;
        state_next = S_OUT;
      end
      S_LREAD: begin
        if (stat.loop_done) begin
          cmd.ap_init = 1'b1;
          state_next = S_APREAD;
        end else begin
          cmd.loop_read = 1'b1;
          cnt_next = '0;
          state_next = S_LMUL;
        end
      end
      S_LMUL: begin
        cnt_next = cnt + 1'b1;
        if (cnt == 2'd3) state_next = S_LRED;
      end
      S_LRED: begin
        cmd.loop_red = 1'b1;
        state_next = S_LCMP;
      end
      S_LCMP: begin
        cmd.loop_cmp = 1'b1;
        state_next = S_LREAD;
      end
      S_APREAD: begin
        if (stat.ap_done) begin
          cmd.load_out = 1'b1; cmd.out_kind = KIND_MERGE;
          state_next = S_OUT;
        end else begin
          cmd.ap_read = 1'b1;
          state_next = S_APWR;
        end
      end
      S_APWR: begin
        cmd.ap_write = 1'b1;
        state_next = S_APREAD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: sv/rhom_checker.sv
// port-level checker bound to the top level
`include "assert_macros.svh"
module rhom_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_kind,
  input logic [12:0] out_overlap,
  input logic [7:0] out_byte,
  input logic out_ovf
);
  `ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_byte))
  `ASSERT_IMPL(a_excl, out_valid, !in_ready)
  `ASSERT_IMPL(a_rd_ovl, out_valid && out_kind, out_overlap == 13'd0)
  `ASSERT_IMPL(a_mg_byte, out_valid && !out_kind, out_byte == 8'd0)
  `ASSERT_NEXT(a_ovf, out_valid && out_ready && out_ovf, !out_valid || out_ovf)
endmodule

bind rolling_hash_overlap_merge rhom_checker u_chk (.clk(clk), .rst(rst),
  .in_valid(in.valid), .in_ready(in.ready), .out_valid(out.valid),
  .out_ready(out.ready), .out_kind(out.kind), .out_overlap(out.overlap_len),
  .out_byte(out.read_byte), .out_ovf(out.overflow));
